// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the ESC failsafe controller.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("check failed");
// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("check failed");
`else
`define ASSERT_CLK(lbl, prop, clk, rst_n)
`define ASSERT_NEXT(lbl, pre, post, clk, rst_n)
`endif
`endif

// File: hdl/escfs_pkg.sv
// Types, constants and the pulse mapping of the ESC failsafe controller.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package escfs_pkg;

  localparam int unsigned SPEED_W = 16;
  localparam int unsigned PULSE_W = 21;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned BIDX_W  = 4;
  localparam int unsigned BITS_W  = 16;
  localparam int unsigned BCNT_W  = 5;
  localparam int unsigned ACNT_W  = 4;
  localparam int unsigned APB_AW  = 5;
  localparam int unsigned APB_DW  = 32;

  localparam logic signed [SPEED_W-1:0] Q_ONE     = 16'sd16384;
  localparam logic signed [SPEED_W-1:0] Q_NEG_ONE = -16'sd16384;
  localparam logic signed [SPEED_W-1:0] Q_ZERO    = 16'sd0;

  // 500000 / 16384 reduces to 15625 / 512
  localparam logic [PULSE_W-1:0] PULSE_BASE_NS = 21'd1000000;
  localparam logic [13:0]        PULSE_MUL     = 14'd15625;
  localparam int unsigned        PULSE_SHIFT   = 9;

  // triggers count only when the sample carries more axes than this
  localparam logic [ACNT_W-1:0]  TRIG_AXES     = 4'd5;

  typedef enum logic [1:0] {
    CMD_SPEED = 2'd0,
    CMD_JOY   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_MIN_SPEED   = 3'd0,
    REG_MAX_SPEED   = 3'd1,
    REG_BOOST_SPEED = 3'd2,
    REG_BOOST_IDX   = 3'd3,
    REG_WDOG_EN     = 3'd4,
    REG_TIMEOUT     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [SPEED_W-1:0] spd_lo;
    logic signed [SPEED_W-1:0] spd_hi;
    logic signed [SPEED_W-1:0] boost_speed;
    logic [BIDX_W-1:0]         boost_idx;
    logic                      wdog_en;
    logic [TICK_W-1:0]         timeout;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    spd_lo:      -16'sd16384,
    spd_hi:      16'sd16384,
    boost_speed: 16'sd16384,
    boost_idx:   4'd1,
    wdog_en:     1'b1,
    timeout:     16'd10
  };

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic                      stop;
    logic                      last;
  } result_t;

  // results of one item handed together from the command stage to the result queue
  typedef struct packed {
    logic [1:0]     cnt;
    result_t [1:0]  res;
  } push_t;

  // Clamp to [-1, +1], then map linearly onto 1..2 ms, truncated.
  function automatic logic [PULSE_W-1:0] pulse_of(input logic signed [SPEED_W-1:0] s);
    logic signed [SPEED_W-1:0] d;
    logic [SPEED_W-1:0]        ofs;
    logic [29:0]               prod;
    d = s;
    if (s > Q_ONE) begin
      d = Q_ONE;
    end else if (s < Q_NEG_ONE) begin
      d = Q_NEG_ONE;
    end
    ofs  = unsigned'(d) + unsigned'(Q_ONE);
    prod = 30'(ofs) * 30'(PULSE_MUL);
    return PULSE_BASE_NS + PULSE_W'(prod >> PULSE_SHIFT);
  endfunction

endpackage

`default_nettype wire

// File: hdl/escfs_regs.sv
// APB-style configuration registers of the ESC failsafe controller.
// Depends on escfs_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module escfs_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [escfs_pkg::APB_AW-1:0] paddr,
  input  wire logic [escfs_pkg::APB_DW-1:0] pwdata,
  output logic      [escfs_pkg::APB_DW-1:0] prdata,
  output logic                             pready,
  output escfs_pkg::cfg_t                  cfg_o
);
  import escfs_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_MIN_SPEED:   cfg_q.spd_lo      <= signed'(pwdata[SPEED_W-1:0]);
        REG_MAX_SPEED:   cfg_q.spd_hi      <= signed'(pwdata[SPEED_W-1:0]);
        REG_BOOST_SPEED: cfg_q.boost_speed <= signed'(pwdata[SPEED_W-1:0]);
        REG_BOOST_IDX:   cfg_q.boost_idx   <= pwdata[BIDX_W-1:0];
        REG_WDOG_EN:     cfg_q.wdog_en     <= pwdata[0];
        REG_TIMEOUT:     cfg_q.timeout     <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_SPEED:   prdata = APB_DW'(cfg_q.spd_lo);
      REG_MAX_SPEED:   prdata = APB_DW'(cfg_q.spd_hi);
      REG_BOOST_SPEED: prdata = APB_DW'(cfg_q.boost_speed);
      REG_BOOST_IDX:   prdata = APB_DW'(cfg_q.boost_idx);
      REG_WDOG_EN:     prdata = APB_DW'(cfg_q.wdog_en);
      REG_TIMEOUT:     prdata = APB_DW'(cfg_q.timeout);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/escfs_ctrl.sv
// Command stage: input register, command decode, stop/boost/idle state.
// Depends on escfs_pkg and assert_macros.svh; feeds escfs_outq.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module escfs_ctrl #(
  parameter int unsigned BUTTON_SLOTS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  escfs_pkg::cfg_t                         cfg_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [1:0]                         command_i,
  input  wire logic signed [escfs_pkg::SPEED_W-1:0] speed_value_i,
  input  wire logic [escfs_pkg::BITS_W-1:0]       button_bits_i,
  input  wire logic [escfs_pkg::BCNT_W-1:0]       button_count_i,
  input  wire logic [escfs_pkg::ACNT_W-1:0]       axis_count_i,
  input  wire logic signed [escfs_pkg::SPEED_W-1:0] right_trigger_i,
  input  wire logic signed [escfs_pkg::SPEED_W-1:0] left_trigger_i,
  input  wire logic [1:0]                         free_i,
  output escfs_pkg::push_t                        push_o
);
  import escfs_pkg::*;

  // input register
  logic                      iv_q;
  cmd_e                      cmd_q;
  logic signed [SPEED_W-1:0] spd_q;
  logic [BITS_W-1:0]         bits_q;
  logic [BCNT_W-1:0]         bcnt_q;
  logic [ACNT_W-1:0]         acnt_q;
  logic signed [SPEED_W-1:0] rt_q;
  logic signed [SPEED_W-1:0] lt_q;

  // block state
  logic              stop_q, stop_d;
  logic              boost_q, boost_d;
  logic [TICK_W-1:0] idle_q, idle_d;

  logic                      adv;
  logic [1:0]                n;
  result_t                   r0, r1;
  logic                      b0, bp, rel, trig;
  logic signed [SPEED_W:0]   diff;
  logic signed [SPEED_W-1:0] half;
  logic [TICK_W-1:0]         idle_inc;

  function automatic logic pressed(input logic [BITS_W-1:0] bits,
                                   input logic [BCNT_W-1:0] cnt,
                                   input logic [BIDX_W-1:0] idx);
    return ({1'b0, idx} < cnt) && (int'(idx) < int'(BUTTON_SLOTS)) && bits[idx];
  endfunction

  function automatic logic signed [SPEED_W-1:0] clamp(input logic signed [SPEED_W-1:0] s,
                                                      input logic signed [SPEED_W-1:0] lo,
                                                      input logic signed [SPEED_W-1:0] hi);
    logic signed [SPEED_W-1:0] v;
    v = (s > hi) ? hi : s;
    v = (v < lo) ? lo : v;
    return v;
  endfunction

  always_comb begin
    b0       = pressed(bits_q, bcnt_q, '0);
    bp       = pressed(bits_q, bcnt_q, cfg_i.boost_idx);
    // floor of the half difference: drop the low bit of the 17-bit difference
    diff     = (SPEED_W+1)'(lt_q) - (SPEED_W+1)'(rt_q);
    half     = diff[SPEED_W:1];
    idle_inc = (idle_q == '1) ? idle_q : idle_q + 1'b1;
    rel      = boost_q;
    trig     = acnt_q > TRIG_AXES;

    n       = 2'd0;
    r0      = '0;
    r1      = '0;
    stop_d  = stop_q;
    boost_d = boost_q;
    idle_d  = idle_q;

    case (cmd_q)
      CMD_SPEED: begin
        idle_d = '0;
        if (!stop_q) begin
          n        = 2'd1;
          r0.speed = clamp(spd_q, cfg_i.spd_lo, cfg_i.spd_hi);
        end
      end
      CMD_JOY: begin
        idle_d = '0;
        if (b0) begin
          if (!stop_q) begin
            n       = 2'd1;
            r0.stop = 1'b1;
            stop_d  = 1'b1;
            boost_d = 1'b0;
          end
        end else if (!stop_q) begin
          if (bp) begin
            if (!boost_q) begin
              boost_d  = 1'b1;
              n        = 2'd1;
              r0.speed = clamp(cfg_i.boost_speed, cfg_i.spd_lo, cfg_i.spd_hi);
            end
          end else begin
            // release result first, then the trigger speed
            boost_d  = 1'b0;
            n        = 2'(rel) + 2'(trig);
            r0.speed = rel ? clamp(Q_ZERO, cfg_i.spd_lo, cfg_i.spd_hi)
                           : clamp(half, cfg_i.spd_lo, cfg_i.spd_hi);
            r1.speed = clamp(half, cfg_i.spd_lo, cfg_i.spd_hi);
          end
        end
      end
      CMD_TICK: begin
        idle_d = idle_inc;
        if (cfg_i.wdog_en && (idle_inc > cfg_i.timeout) && !stop_q) begin
          n       = 2'd1;
          r0.stop = 1'b1;
          stop_d  = 1'b1;
          boost_d = 1'b0;
        end
      end
      default: ;
    endcase

    r0.last = (n == 2'd1);
    r1.last = (n == 2'd2);
  end

  // advance only when the queue has room for every result of this item
  assign adv        = iv_q && (n <= free_i);
  assign in_ready_o = !iv_q || adv;

  always_comb begin
    push_o.cnt    = adv ? n : 2'd0;
    push_o.res[0] = r0;
    push_o.res[1] = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q    <= 1'b0;
      stop_q  <= 1'b0;
      boost_q <= 1'b0;
      idle_q  <= '0;
    end else begin
      if (in_ready_o) begin
        iv_q <= in_valid_i;
      end
      if (adv) begin
        stop_q  <= stop_d;
        boost_q <= boost_d;
        idle_q  <= idle_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= cmd_e'(command_i);
      spd_q  <= speed_value_i;
      bits_q <= button_bits_i;
      bcnt_q <= button_count_i;
      acnt_q <= axis_count_i;
      rt_q   <= right_trigger_i;
      lt_q   <= left_trigger_i;
    end
  end

  `ASSERT_NEXT(a_stop_sticky, stop_q, stop_q, clk_i, rst_ni)
  `ASSERT_CLK(a_no_boost_when_stopped, stop_q |-> !boost_q, clk_i, rst_ni)
  `ASSERT_CLK(a_push_bounded, push_o.cnt != 2'd3, clk_i, rst_ni)

endmodule

`default_nettype wire

// File: hdl/escfs_outq.sv
// Two-entry result queue and pulse width mapping at the output port.
// Depends on escfs_pkg and assert_macros.svh; filled by escfs_ctrl.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module escfs_outq (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  escfs_pkg::push_t                         push_i,
  output logic [1:0]                               free_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [escfs_pkg::PULSE_W-1:0]            pulse_ns_o,
  output logic signed [escfs_pkg::SPEED_W-1:0]     speed_feedback_o,
  output logic                                     stop_latched_o,
  output logic                                     last_result_o
);
  import escfs_pkg::*;

  result_t    ent_q [2];
  result_t    ent_d [2];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] base;
  logic       pop;

  assign pop    = (cnt_q != 2'd0) && out_ready_i;
  assign free_o = 2'd2 - cnt_q + {1'b0, pop};
  assign base   = cnt_q - {1'b0, pop};

  always_comb begin
    ent_d[0] = ent_q[0];
    ent_d[1] = ent_q[1];
    if (pop) begin
      ent_d[0] = ent_q[1];
    end
    // append after whatever stays queued
    if (push_i.cnt != 2'd0) begin
      if (base == 2'd0) begin
        ent_d[0] = push_i.res[0];
        ent_d[1] = push_i.res[1];
      end else begin
        ent_d[1] = push_i.res[0];
      end
    end
    cnt_d = base + push_i.cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

  assign out_valid_o      = cnt_q != 2'd0;
  assign speed_feedback_o = ent_q[0].speed;
  assign stop_latched_o   = ent_q[0].stop;
  assign last_result_o    = ent_q[0].last;
  assign pulse_ns_o       = pulse_of(ent_q[0].speed);

  `ASSERT_CLK(a_cnt_in_range, cnt_q != 2'd3, clk_i, rst_ni)
  `ASSERT_CLK(a_no_overflow, push_i.cnt <= free_o, clk_i, rst_ni)
  `ASSERT_CLK(a_stop_is_neutral, out_valid_o && stop_latched_o |-> speed_feedback_o == Q_ZERO,
              clk_i, rst_ni)

endmodule

`default_nettype wire

// File: hdl/esc_command_failsafe_controller_core.sv
// ESC command and failsafe controller: speed commands, joystick samples and ticks in,
// ESC pulse width results out. The first result passes the input register and then the
// queue register before it is valid; the command stage stalls while the queue lacks room.
// One item per cycle while each yields at most one result and the output is ready; items
// with two results are slowed by the single result port draining the two-entry queue.
// Reset clears the stop latch, boost flag, idle count and queue, and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module esc_command_failsafe_controller_core #(
  parameter int unsigned BUTTON_SLOTS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [escfs_pkg::APB_AW-1:0]          paddr,
  input  wire logic [escfs_pkg::APB_DW-1:0]          pwdata,
  output logic      [escfs_pkg::APB_DW-1:0]          prdata,
  output logic                                       pready,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [1:0]                            command_i,
  input  wire logic signed [escfs_pkg::SPEED_W-1:0]  speed_value_i,
  input  wire logic [escfs_pkg::BITS_W-1:0]          button_bits_i,
  input  wire logic [escfs_pkg::BCNT_W-1:0]          button_count_i,
  input  wire logic [escfs_pkg::ACNT_W-1:0]          axis_count_i,
  input  wire logic signed [escfs_pkg::SPEED_W-1:0]  right_trigger_i,
  input  wire logic signed [escfs_pkg::SPEED_W-1:0]  left_trigger_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [escfs_pkg::PULSE_W-1:0]              pulse_ns_o,
  output logic signed [escfs_pkg::SPEED_W-1:0]       speed_feedback_o,
  output logic                                       stop_latched_o,
  output logic                                       last_result_o
);
  import escfs_pkg::*;

  cfg_t       cfg;
  push_t      push;
  logic [1:0] free;

  escfs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  escfs_ctrl #(
    .BUTTON_SLOTS (BUTTON_SLOTS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .speed_value_i   (speed_value_i),
    .button_bits_i   (button_bits_i),
    .button_count_i  (button_count_i),
    .axis_count_i    (axis_count_i),
    .right_trigger_i (right_trigger_i),
    .left_trigger_i  (left_trigger_i),
    .free_i          (free),
    .push_o          (push)
  );

  escfs_outq u_outq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .free_o           (free),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pulse_ns_o       (pulse_ns_o),
    .speed_feedback_o (speed_feedback_o),
    .stop_latched_o   (stop_latched_o),
    .last_result_o    (last_result_o)
  );

endmodule

`default_nettype wire
